FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: rtl/core/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Types and constants shared by the laser line centroid and height block.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 512;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 9;
  localparam int PIX_W     = 8;
  localparam int MASS_W    = 18;
  localparam int MOM_W     = 28;
  localparam int NUM_W     = MOM_W + 8;
  localparam int CEN_W     = 18;
  localparam int HGT_W     = 21;
  localparam int COEF_W    = 21;
  localparam int CREG_W    = 63;
  localparam int CNT_W     = 5;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int CFG_IDX_W = 4;

  localparam logic [PIX_W-1:0] THRESH_RESET = 8'd150;

  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONST  = 4'd3;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [MASS_W-1:0] mass;
    logic [MOM_W-1:0]  moment;
    logic              last;
  } row_rec_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic [CEN_W-1:0]        centroid;
    logic signed [HGT_W-1:0] height_mm;
    logic                    line_found;
    logic                    last_row;
  } result_t;

  typedef struct packed {
    logic [CREG_W-1:0] square;
    logic [CREG_W-1:0] linear;
    logic [CREG_W-1:0] cst;
  } coeff_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV, B_IN_A, B_IN_B, B_IN_C, B_IN_D,
    B_OUT_A, B_OUT_B, B_OUT_C, B_OUT_D, B_OUT_E, B_FIN
  } back_state_t;

endpackage

FILE: rtl/core/lcc_front.sv
// ----------------------------------------------------------------------------
// lcc_front
// Thresholds pixels and accumulates row mass and moment, one pixel a cycle while the row queue has room.
// ----------------------------------------------------------------------------
module lcc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pix_valid,
  output logic                     pix_ready,
  input  logic [lcc_pkg::PIX_W-1:0] pixel,
  input  logic                     row_end,
  input  logic                     frame_end,
  input  logic [lcc_pkg::PIX_W-1:0] thresh,
  input  lcc_pkg::q_status_t       q_status,
  output logic                     rec_push,
  output lcc_pkg::row_rec_t        rec
);
  import lcc_pkg::*;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [MASS_W-1:0] row_mass;
  logic [MOM_W-1:0]  row_moment;

  logic [PIX_W-1:0]  counted;
  logic              in_range;
  logic [MASS_W-1:0] mass_sum;
  logic [MOM_W-1:0]  moment_sum;
  logic              accept;
  logic              closing;

  always_comb begin
    counted    = (pixel > thresh) ? pixel : '0;
    in_range   = column_count < COL_W'(MAX_COLS);
    mass_sum   = row_mass;
    moment_sum = row_moment;
    if (in_range) begin
      mass_sum   = row_mass + MASS_W'(counted);
      moment_sum = row_moment + MOM_W'(column_count[COL_W-2:0]) * MOM_W'(counted);
    end
  end

  assign pix_ready  = !q_status.full;
  assign accept     = pix_valid && pix_ready;
  assign closing    = row_end || frame_end;
  assign rec_push   = accept && closing;
  assign rec.row    = row_count;
  assign rec.mass   = mass_sum;
  assign rec.moment = moment_sum;
  assign rec.last   = frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_mass     <= '0;
      row_moment   <= '0;
    end else if (accept) begin
      if (closing) begin
        column_count <= '0;
        row_mass     <= '0;
        row_moment   <= '0;
        if (frame_end) begin
          row_count <= '0;
        end else if (row_count < ROW_W'(MAX_ROWS - 1)) begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        row_mass   <= mass_sum;
        row_moment <= moment_sum;
        if (in_range) begin
          column_count <= column_count + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/lcc_queue.sv
// ----------------------------------------------------------------------------
// lcc_queue
// Short register queue of closed-row records between front and back.
// ----------------------------------------------------------------------------
module lcc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcc_pkg::row_rec_t  wdata,
  input  logic               pop,
  output lcc_pkg::row_rec_t  rdata,
  output lcc_pkg::q_status_t status
);
  import lcc_pkg::*;

  row_rec_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp;
  logic [Q_PTR_W-1:0] rp;
  logic [Q_PTR_W:0]   count;

  assign rdata        = entries[rp];
  assign status.full  = count == (Q_PTR_W+1)'(Q_DEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= wdata;
    end
  end

endmodule

FILE: rtl/core/lcc_back.sv
// ----------------------------------------------------------------------------
// lcc_back
// Per-row sequencer: restoring divide for the centroid, then the calibration
// polynomial through one shared registered multiplier.
// ----------------------------------------------------------------------------
module lcc_back (
  input  logic                clk,
  input  logic                rst,
  input  lcc_pkg::row_rec_t   head,
  input  lcc_pkg::q_status_t  q_status,
  output logic                pop,
  input  lcc_pkg::coeff_set_t coeffs,
  output lcc_pkg::result_t    res,
  output logic                res_valid,
  input  logic                res_ready
);
  import lcc_pkg::*;

  back_state_t state, state_next;

  row_rec_t                 cur;
  logic [MASS_W:0]          rem;
  logic [MASS_W-1:0]        nlo;
  logic [CEN_W-1:0]         quo;
  logic [CNT_W-1:0]         cnt;
  logic [1:0]               k;
  logic signed [43:0]       tt;
  logic signed [50:0]       prod;
  logic signed [63:0]       acc;
  logic signed [22:0]       p [3];

  logic signed [31:0]       ma;
  logic [CEN_W-1:0]         mb;
  logic [CREG_W-1:0]        csel;
  logic signed [COEF_W-1:0] a_f, b_f, c_f;
  logic [NUM_W-1:0]         num;
  logic [MASS_W:0]          shifted;
  logic signed [43:0]       g;
  logic signed [63:0]       hs;
  logic signed [HGT_W-1:0]  h_sat;
  logic                     load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = (head.mass != '0) ? B_DIV : B_FIN;
        end
      end
      B_DIV:   if (cnt == CNT_W'(CEN_W - 1)) state_next = B_IN_A;
      B_IN_A:  state_next = B_IN_B;
      B_IN_B:  state_next = B_IN_C;
      B_IN_C:  state_next = B_IN_D;
      B_IN_D:  state_next = (k == 2'd2) ? B_OUT_A : B_IN_A;
      B_OUT_A: state_next = B_OUT_B;
      B_OUT_B: state_next = B_OUT_C;
      B_OUT_C: state_next = B_OUT_D;
      B_OUT_D: state_next = B_OUT_E;
      B_OUT_E: state_next = B_FIN;
      B_FIN: begin
        if (!res_valid || res_ready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    case (k)
      2'd0:    csel = coeffs.square;
      2'd1:    csel = coeffs.linear;
      default: csel = coeffs.cst;
    endcase
    a_f = signed'(csel[COEF_W-1:0]);
    b_f = signed'(csel[2*COEF_W-1:COEF_W]);
    c_f = signed'(csel[3*COEF_W-1:2*COEF_W]);
  end

  // Operand selection for the shared multiplier; the product is registered.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      B_IN_A: begin
        ma = 32'(a_f);
        mb = CEN_W'(cur.row);
      end
      B_IN_C: begin
        ma = 32'(tt);
        mb = CEN_W'(cur.row);
      end
      B_OUT_A: begin
        ma = 32'(p[0]);
        mb = quo;
      end
      B_OUT_C: begin
        ma = 32'(tt >>> 22);
        mb = quo;
      end
      B_OUT_D: begin
        ma = signed'({10'b0, tt[21:0]});
        mb = quo;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    num     = {head.moment, 8'b0};
    shifted = {rem[MASS_W-1:0], nlo[MASS_W-1]};
    g       = 44'(prod) + (44'(c_f) <<< 18);
    // Round to nearest Q12.8 with halves going up, then saturate.
    hs      = (acc + 64'sd35184372088832) >>> 46;
    if (hs > 64'sd1048575) begin
      h_sat = 21'sd1048575;
    end else if (hs < -64'sd1048576) begin
      h_sat = -21'sd1048576;
    end else begin
      h_sat = HGT_W'(hs);
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * signed'({1'b0, mb});
    case (state)
      B_IDLE: begin
        cur <= head;
        rem <= {1'b0, num[NUM_W-1 -: MASS_W]};
        nlo <= num[MASS_W-1:0];
        quo <= '0;
        cnt <= '0;
        k   <= '0;
      end
      B_DIV: begin
        if (shifted >= {1'b0, cur.mass}) begin
          rem <= shifted - {1'b0, cur.mass};
          quo <= {quo[CEN_W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[CEN_W-2:0], 1'b0};
        end
        nlo <= {nlo[MASS_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      B_IN_B:  tt <= 44'(prod) + (44'(b_f) <<< 9);
      B_IN_D: begin
        p[k] <= 23'(g >>> 18);
        k    <= k + 1'b1;
      end
      B_OUT_B: tt  <= 44'(prod) + (44'(p[1]) <<< 18);
      B_OUT_D: acc <= 64'(prod) <<< 22;
      B_OUT_E: acc <= acc + 64'(prod) + (64'(p[2]) <<< 36);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.row_index  <= cur.row;
      res.centroid   <= quo;
      res.height_mm  <= (cur.mass != '0) ? h_sat : '0;
      res.line_found <= cur.mass != '0;
      res.last_row   <= cur.last;
    end
  end

endmodule

FILE: rtl/core/laser_line_centroid_height.sv
// Throughput: one pixel per cycle while the row queue has room.
// Each closed row with nonzero mass passes through the back sequencer in 18
// divide steps, 17 multiplier steps, load and output; rows that arrive faster
// than that stall the pixel stream once the two-entry queue fills.
// Synchronous reset clears all control state and loads the register resets.
// ----------------------------------------------------------------------------
// laser_line_centroid_height
// Laser line centroid per row with biquadratic height calibration.
// ----------------------------------------------------------------------------
module laser_line_centroid_height (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [7:0] pixel
  input  logic                          s_tlast,  // row_end
  input  logic                          s_tuser,  // frame_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [8:0] row_index, [26:9] centroid, [47:27] height_mm, [48] line_found
  output logic [55:0]                   m_tdata,
  output logic                          m_tlast,  // last_row
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcc_pkg::CREG_W-1:0]    cfg_data
);
  import lcc_pkg::*;

  logic [PIX_W-1:0] thresh;
  coeff_set_t       coeffs;
  q_status_t        q_status;
  row_rec_t         rec, head;
  logic             rec_push, pop;
  result_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
      coeffs <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESH: thresh        <= cfg_data[PIX_W-1:0];
        REG_SQUARE: coeffs.square <= cfg_data;
        REG_LINEAR: coeffs.linear <= cfg_data;
        REG_CONST:  coeffs.cst    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .pixel     (s_tdata),
    .row_end   (s_tlast),
    .frame_end (s_tuser),
    .thresh    (thresh),
    .q_status  (q_status),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  lcc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (rec_push),
    .wdata  (rec),
    .pop    (pop),
    .rdata  (head),
    .status (q_status)
  );

  lcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .coeffs    (coeffs),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = {7'b0, res.line_found, res.height_mm, res.centroid, res.row_index};
  assign m_tlast = res.last_row;

endmodule

FILE: rtl/core/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks on the laser line centroid and height block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [3:0]  cfg_index,
  input logic [62:0] cfg_data
);

  // A stalled result stays offered and unchanged.
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `ASSERT_CLK(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata))
  // An empty row carries zero centroid and height.
  `ASSERT_CLK(a_empty_zero, clk, rst, m_tvalid && !m_tdata[48] |-> m_tdata[47:9] == 39'd0)
  // No result is offered straight after reset.
  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !m_tvalid)

endmodule

bind laser_line_centroid_height lcc_checker u_lcc_checker (.*);
